// ----- rtl/lspg_pkg.sv -----
// shared types, constants and helper functions for the led strip pattern generator
// no dependencies; imported by the top level and its checker

package lspg_pkg;

   localparam int unsigned MAX_PIXELS = 1024;

   localparam int unsigned INDEX_W  = 10;
   localparam int unsigned STEP_W   = 32;
   localparam int unsigned LENGTH_W = 11;
   localparam int unsigned GRB_W    = 24;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned ADDR_W   = 4;

   localparam logic [LENGTH_W-1:0] STRIP_LENGTH_RESET = LENGTH_W'(60);
   localparam logic [CSR_W-1:0]    RANDOM_SEED_RESET  = 32'd1;

   localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

   localparam logic [GRB_W-1:0] COL_RED   = 24'h00FF00;
   localparam logic [GRB_W-1:0] COL_GREEN = 24'hFF0000;
   localparam logic [GRB_W-1:0] COL_BLUE  = 24'h0000FF;
   localparam logic [GRB_W-1:0] COL_WHITE = 24'hFFFFFF;
   localparam logic [GRB_W-1:0] COL_BLACK = 24'h000000;

   // greys: x / 100 as (x * 5243) >> 19, exact for x below 43690
   localparam int unsigned GREY_FOLD_W  = 15;
   localparam int unsigned GREY_RECIP   = 5243;
   localparam int unsigned GREY_SHIFT   = 19;
   localparam int unsigned GREY_PROD_W  = GREY_FOLD_W + 13;
   // byte weights of 2^8, 2^16, 2^24 modulo 100
   localparam int unsigned GREY_W1 = 56;
   localparam int unsigned GREY_W2 = 36;
   localparam int unsigned GREY_W3 = 16;

   // police: len / 6 as (len * 683) >> 12, exact for len below 2048
   localparam int unsigned SIX_RECIP = 683;
   localparam int unsigned SIX_SHIFT = 12;

   localparam logic [7:0] BREATH_KNEE_LO = 8'd150;
   localparam logic [7:0] BREATH_KNEE_HI = 8'd190;
   localparam logic [7:0] BREATH_TOP     = 8'hFF;
   localparam logic [3:0] BREATH_PAUSE_END = 4'd8;

   typedef enum logic [2:0] {
      MODE_BLANK   = 3'd0,
      MODE_SNAKES  = 3'd1,
      MODE_SCAN    = 3'd2,
      MODE_RANDOM  = 3'd3,
      MODE_SPARKLE = 3'd4,
      MODE_GREYS   = 3'd5,
      MODE_POLICE  = 3'd6,
      MODE_BREATH  = 3'd7
   } pattern_mode_type;

   typedef enum logic [1:0] {
      REG_MODE   = 2'd0,
      REG_LENGTH = 2'd1,
      REG_SEED   = 2'd2
   } csr_index_type;

   localparam logic [1:0] BREATH_RISE  = 2'd0;
   localparam logic [1:0] BREATH_FALL  = 2'd1;
   localparam logic [1:0] BREATH_PAUSE = 2'd2;

   localparam logic [1:0] SCAN_RED   = 2'd0;
   localparam logic [1:0] SCAN_GREEN = 2'd1;
   localparam logic [1:0] SCAN_BLUE  = 2'd2;

   // values derived from the strip length, captured when the length is written
   typedef struct packed {
      logic [INDEX_W-1:0] last;   // effective length - 1
      logic [INDEX_W-1:0] half;   // effective length / 2
      logic [7:0]         seg1;   // len / 6
      logic [8:0]         seg2;
      logic [9:0]         seg4;
      logic [9:0]         seg5;
   } len_cfg_type;

   function automatic len_cfg_type len_config(input logic [LENGTH_W-1:0] raw);
      logic [LENGTH_W-1:0] eff;
      logic [21:0]         prod;
      len_cfg_type         cfg;
      eff = raw;
      if (raw == '0) begin
         eff = LENGTH_W'(1);
      end else if (raw > LENGTH_W'(MAX_PIXELS)) begin
         eff = LENGTH_W'(MAX_PIXELS);
      end
      prod      = 22'(eff) * 22'(SIX_RECIP);
      cfg.last  = INDEX_W'(eff - LENGTH_W'(1));
      cfg.half  = INDEX_W'(eff >> 1);
      cfg.seg1  = prod[SIX_SHIFT +: 8];
      cfg.seg2  = {cfg.seg1, 1'b0};
      cfg.seg4  = {cfg.seg1, 2'b00};
      cfg.seg5  = {cfg.seg1, 2'b00} + {2'b00, cfg.seg1};
      return cfg;
   endfunction

   // one step of the galois lfsr, never landing on zero
   function automatic logic [31:0] lfsr_next(input logic [31:0] cur);
      logic [31:0] nxt;
      nxt = {1'b0, cur[31:1]} ^ (cur[0] ? LFSR_TAPS : 32'd0);
      if (nxt == '0) begin
         nxt = 32'd1;
      end
      return nxt;
   endfunction

endpackage

// ----- rtl/led_strip_pattern_generator.sv -----
// top level of the led strip pattern generator: request register, pattern logic,
// response register, animation state and apb-style register file; uses lspg_pkg
//
// usage
//   one request per pixel: req_pixel_index and req_frame_step, taken when req_valid
//   is high and req_stall low. each request gives one response (rsp_pixel_grb in
//   green/red/blue byte order, rsp_frame_last on the last pixel of the frame), except
//   in random and sparkle modes, where a frame step that is not a multiple of 8 is
//   consumed and gives no response.
//   path: a taken request is held in the request register, then in the response register.
//   throughput: one pixel per cycle while the response is not stalled, set by the single
//   register-to-register pass of the pattern logic; scan, police, breath and lfsr state
//   update in that same pass, so the following pixel already sees it.
//   stall: while rsp_stall holds a response, the request register holds too and
//   req_stall rises once it is full; skipped requests drain regardless.
//   reset: synchronous; clears both registers, the animation state, and loads the
//   register defaults (blank mode, 60 pixels, seed 1).
//   registers: mode at 0x0, strip length at 0x4, random seed at 0x8; writing the
//   seed also reloads the lfsr (zero loads as 1). write only while idle.

module led_strip_pattern_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lspg_pkg::INDEX_W-1:0]         req_pixel_index,
   input  logic [lspg_pkg::STEP_W-1:0]          req_frame_step,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lspg_pkg::GRB_W-1:0]           rsp_pixel_grb,
   output logic                                 rsp_frame_last,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lspg_pkg::ADDR_W-1:0]          paddr,
   input  logic [lspg_pkg::CSR_W-1:0]           pwdata,
   output logic [lspg_pkg::CSR_W-1:0]           prdata,
   output logic                                 pready
);
   import lspg_pkg::*;

   // ---------------- register file ----------------
   pattern_mode_type      mode_ff;
   logic [LENGTH_W-1:0]   strip_length_ff;
   logic [CSR_W-1:0]      seed_ff;
   len_cfg_type           len_cfg_ff;
   csr_index_type         csr_index;
   logic                  csr_write;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      unique case (csr_index)
         REG_MODE:   prdata = {(CSR_W-3)'(0), mode_ff};
         REG_LENGTH: prdata = {(CSR_W-LENGTH_W)'(0), strip_length_ff};
         REG_SEED:   prdata = seed_ff;
         default:    prdata = '0;
      endcase
   end

   // length-derived bounds are computed from the write data so they are ready
   // together with the length itself
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_BLANK;
         strip_length_ff <= STRIP_LENGTH_RESET;
         len_cfg_ff      <= len_config(STRIP_LENGTH_RESET);
         seed_ff         <= RANDOM_SEED_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MODE:   mode_ff <= pattern_mode_type'(pwdata[2:0]);
            REG_LENGTH: begin
               strip_length_ff <= pwdata[LENGTH_W-1:0];
               len_cfg_ff      <= len_config(pwdata[LENGTH_W-1:0]);
            end
            REG_SEED:   seed_ff <= pwdata;
            default:    ;
         endcase
      end
   end

   // ---------------- request register ----------------
   logic                    in_valid_ff;
   logic [INDEX_W-1:0]      in_index_ff;
   logic [6:0]              in_step_ff;     // frame step bits 6:0 for snakes and skip
   logic [GREY_FOLD_W-1:0]  in_grey_ff;     // frame step folded mod 100, plus index
   logic [GREY_FOLD_W-1:0]  grey_fold_in;
   logic                    req_take;
   logic                    skip;
   logic                    advance;

   // 2^32 folded by bytes with weights 2^8k mod 100; stays below 28819
   assign grey_fold_in = GREY_FOLD_W'(req_frame_step[31:24]) * GREY_FOLD_W'(GREY_W3)
                       + GREY_FOLD_W'(req_frame_step[23:16]) * GREY_FOLD_W'(GREY_W2)
                       + GREY_FOLD_W'(req_frame_step[15:8])  * GREY_FOLD_W'(GREY_W1)
                       + GREY_FOLD_W'(req_frame_step[7:0])
                       + GREY_FOLD_W'(req_pixel_index);

   // random and sparkle skip frame steps that are not multiples of 8
   assign skip    = ((mode_ff == MODE_RANDOM) || (mode_ff == MODE_SPARKLE))
                    && (in_step_ff[2:0] != 3'd0);
   assign advance = in_valid_ff && (skip || !rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_index_ff <= req_pixel_index;
         in_step_ff  <= req_frame_step[6:0];
         in_grey_ff  <= grey_fold_in;
      end
   end

   // ---------------- animation state ----------------
   logic [INDEX_W-1:0] scan_pos_ff,  scan_pos_in;
   logic               scan_rev_ff,  scan_rev_in;
   logic [1:0]         scan_col_ff,  scan_col_in;
   logic               police_ff,    police_in;
   logic [7:0]         breath_lvl_ff, breath_lvl_in;
   logic [1:0]         breath_ph_ff,  breath_ph_in;
   logic [3:0]         breath_pau_ff, breath_pau_in;
   logic [31:0]        noise_ff,      noise_in;

   logic               is_last;
   logic [31:0]        noise_step;
   logic [1:0]         scan_col_next;
   logic [INDEX_W-1:0] scan_up;
   logic [INDEX_W-1:0] scan_down;
   logic [3:0]         breath_step;
   logic [8:0]         breath_sum;
   logic [3:0]         breath_pau_inc;

   assign is_last       = (in_index_ff == len_cfg_ff.last);
   assign noise_step    = lfsr_next(noise_ff);
   assign scan_col_next = (scan_col_ff >= SCAN_BLUE) ? SCAN_RED : scan_col_ff + 2'd1;
   assign scan_up       = scan_pos_ff + INDEX_W'(1);
   assign scan_down     = scan_pos_ff - INDEX_W'(1);

   // breath speeds up near full brightness
   assign breath_step = 4'd1 + ((breath_lvl_ff > BREATH_KNEE_LO) ? 4'd5 : 4'd0)
                             + ((breath_lvl_ff > BREATH_KNEE_HI) ? 4'd7 : 4'd0);
   assign breath_sum     = {1'b0, breath_lvl_ff} + 9'(breath_step);
   assign breath_pau_inc = breath_pau_ff + 4'd1;

   always_comb begin
      scan_pos_in   = scan_pos_ff;
      scan_rev_in   = scan_rev_ff;
      scan_col_in   = scan_col_ff;
      police_in     = police_ff;
      breath_lvl_in = breath_lvl_ff;
      breath_ph_in  = breath_ph_ff;
      breath_pau_in = breath_pau_ff;
      noise_in      = noise_ff;

      if (csr_write && (csr_index == REG_SEED)) begin
         noise_in = (pwdata == '0) ? 32'd1 : pwdata;
      end else if (advance && !skip
                   && ((mode_ff == MODE_RANDOM) || (mode_ff == MODE_SPARKLE))) begin
         noise_in = noise_step;
      end

      if (advance && is_last) begin
         case (mode_ff)
            MODE_SCAN: begin
               if (!scan_rev_ff) begin
                  scan_pos_in = scan_up;
                  if (scan_up >= len_cfg_ff.last) begin
                     scan_rev_in = 1'b1;
                     scan_col_in = scan_col_next;
                  end
               end else if (scan_pos_ff == '0) begin
                  // turning at the bottom end, position stays put
                  scan_rev_in = 1'b0;
                  scan_col_in = scan_col_next;
               end else begin
                  scan_pos_in = scan_down;
                  if (scan_down == '0) begin
                     scan_rev_in = 1'b0;
                     scan_col_in = scan_col_next;
                  end
               end
            end
            MODE_POLICE: police_in = !police_ff;
            MODE_BREATH: begin
               case (breath_ph_ff)
                  BREATH_FALL: begin
                     if (breath_lvl_ff < 8'(breath_step)) begin
                        breath_lvl_in = '0;
                        breath_ph_in  = BREATH_PAUSE;
                     end else begin
                        breath_lvl_in = breath_lvl_ff - 8'(breath_step);
                     end
                  end
                  BREATH_PAUSE: begin
                     breath_pau_in = breath_pau_inc;
                     if (breath_pau_inc == BREATH_PAUSE_END) begin
                        breath_ph_in  = BREATH_RISE;
                        breath_pau_in = '0;
                     end
                  end
                  default: begin
                     // rising, and the unused phase code behaves the same
                     if (breath_sum > 9'(BREATH_TOP)) begin
                        breath_lvl_in = BREATH_TOP;
                        breath_ph_in  = BREATH_FALL;
                     end else begin
                        breath_lvl_in = breath_sum[7:0];
                     end
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pos_ff   <= '0;
         scan_rev_ff   <= 1'b0;
         scan_col_ff   <= SCAN_RED;
         police_ff     <= 1'b0;
         breath_lvl_ff <= '0;
         breath_ph_ff  <= BREATH_RISE;
         breath_pau_ff <= '0;
         noise_ff      <= RANDOM_SEED_RESET;
      end else begin
         scan_pos_ff   <= scan_pos_in;
         scan_rev_ff   <= scan_rev_in;
         scan_col_ff   <= scan_col_in;
         police_ff     <= police_in;
         breath_lvl_ff <= breath_lvl_in;
         breath_ph_ff  <= breath_ph_in;
         breath_pau_ff <= breath_pau_in;
         noise_ff      <= noise_in;
      end
   end

   // ---------------- pattern logic ----------------
   logic [5:0]             snake_x;
   logic [GREY_PROD_W-1:0] grey_prod;
   logic [8:0]             grey_quot;
   logic [GREY_FOLD_W-1:0] grey_q100;
   logic [GREY_FOLD_W-1:0] grey_rem;
   logic [7:0]             grey_v;
   logic                   police_gap;
   logic [GRB_W-1:0]       police_lit;
   logic [GRB_W-1:0]       snake_col;
   logic [GRB_W-1:0]       scan_col;
   logic [GRB_W-1:0]       pixel_col;

   // snakes: 64-pixel repeat, three 10-pixel bands moving every other step
   assign snake_x = in_index_ff[5:0] + in_step_ff[6:1];

   always_comb begin
      if (snake_x < 6'd10) begin
         snake_col = COL_RED;
      end else if ((snake_x >= 6'd15) && (snake_x < 6'd25)) begin
         snake_col = COL_GREEN;
      end else if ((snake_x >= 6'd30) && (snake_x < 6'd40)) begin
         snake_col = COL_BLUE;
      end else begin
         snake_col = COL_BLACK;
      end
   end

   // greys: folded value mod 100 by reciprocal, q*100 as shifts
   assign grey_prod = GREY_PROD_W'(in_grey_ff) * GREY_PROD_W'(GREY_RECIP);
   assign grey_quot = grey_prod[GREY_SHIFT +: 9];
   assign grey_q100 = {grey_quot, 6'b0} + {1'b0, grey_quot, 5'b0}
                    + {4'b0, grey_quot, 2'b0};
   assign grey_rem  = in_grey_ff - grey_q100;
   assign grey_v    = grey_rem[7:0];

   // scan: one lit pixel
   always_comb begin
      if (in_index_ff != scan_pos_ff) begin
         scan_col = COL_BLACK;
      end else if (scan_col_ff == SCAN_RED) begin
         scan_col = COL_RED;
      end else if (scan_col_ff == SCAN_GREEN) begin
         scan_col = COL_GREEN;
      end else begin
         scan_col = COL_BLUE;
      end
   end

   // police: red half and blue half with two dark gap segments; on alternate frames only the gaps are lit
   assign police_gap = (({1'b0, in_index_ff} >= 11'(len_cfg_ff.seg1))
                        && ({1'b0, in_index_ff} < 11'(len_cfg_ff.seg2)))
                    || ((in_index_ff >= len_cfg_ff.seg4) && (in_index_ff < len_cfg_ff.seg5));
   assign police_lit = (in_index_ff < len_cfg_ff.half) ? COL_RED : COL_BLUE;

   always_comb begin
      unique case (mode_ff)
         MODE_SNAKES:  pixel_col = snake_col;
         MODE_SCAN:    pixel_col = scan_col;
         MODE_RANDOM:  pixel_col = noise_step[GRB_W-1:0];
         MODE_SPARKLE: pixel_col = (noise_step[3:0] == 4'd0) ? COL_WHITE : COL_BLACK;
         MODE_GREYS:   pixel_col = {grey_v, grey_v, grey_v};
         MODE_POLICE:  pixel_col = (police_gap ^ police_ff) ? COL_BLACK : police_lit;
         MODE_BREATH:  pixel_col = {breath_lvl_ff, 16'h0000};
         default:      pixel_col = COL_BLACK;
      endcase
   end

   // ---------------- response register ----------------
   logic             out_valid_ff;
   logic [GRB_W-1:0] out_grb_ff;
   logic             out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && !skip) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !skip) begin
         out_grb_ff  <= pixel_col;
         out_last_ff <= is_last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_grb  = out_grb_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

// ----- rtl/lspg_checker.sv -----
// port-level checks for the led strip pattern generator, bound to the top level
// depends on lspg_pkg and led_strip_pattern_generator

module lspg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [lspg_pkg::GRB_W-1:0]    rsp_pixel_grb,
   input logic                          rsp_frame_last,
   input logic                          psel,
   input logic                          penable,
   input logic                          pwrite,
   input logic [lspg_pkg::ADDR_W-1:0]   paddr,
   input logic [lspg_pkg::CSR_W-1:0]    pwdata,
   input logic [lspg_pkg::CSR_W-1:0]    prdata,
   input logic                          pready
);
   import lspg_pkg::*;

   // reset empties the response register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // requests are only held back by a stalled, full response register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without downstream stall");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pixel_grb)
                                    && $stable(rsp_frame_last)))
      else $error("stalled response changed");

   // a mode write reads back on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_MODE))
      ##1 (psel && !pwrite && (paddr[ADDR_W-1:2] == REG_MODE))
      |-> (prdata[2:0] == $past(pwdata[2:0])))
      else $error("mode register readback mismatch");

endmodule

bind led_strip_pattern_generator lspg_checker u_lspg_checker (.*);
